### hdl/dtp_pkg.sv
package dtp_pkg;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_FIRST    = 3'd1,
        PH_AFTER_H  = 3'd2,
        PH_AFTER_M  = 3'd3,
        PH_AFTER_S  = 3'd4,
        PH_FRACTION = 3'd5,
        PH_DONE     = 3'd6
    } dtp_phase_t;

    typedef struct packed {
        logic ok;
        logic negative;
    } dtp_verdict_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H_LO  = 8'h68;
    localparam logic [7:0] CH_H_UP  = 8'h48;
    localparam logic [7:0] CH_M_LO  = 8'h6d;
    localparam logic [7:0] CH_M_UP  = 8'h4d;
    localparam logic [7:0] CH_S_LO  = 8'h73;
    localparam logic [7:0] CH_S_UP  = 8'h53;
    localparam logic [7:0] CH_POINT = 8'h2e;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;

    localparam int unsigned MS_PER_HOUR   = 3600000;
    localparam int unsigned MS_PER_MINUTE = 60000;
    localparam int unsigned MS_PER_SECOND = 1000;
    localparam int unsigned UNIT_LIMIT    = 60;

    localparam int NUM_W     = 10;
    localparam int NUM_MAX   = 1023;
    localparam int FRAC_DIGS = 4;
    localparam int DUR_W     = 32;
    localparam int OUT_W     = 40;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

### hdl/dtp_parser.sv
module dtp_parser
    import dtp_pkg::*;
#(
    parameter int MAX_HOURS = 511,
    parameter int MS_W      = 31
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_fire,
    input  logic [7:0]        text_byte,
    output dtp_verdict_t      verdict,
    output logic [MS_W-1:0]   total_ms
);

    dtp_phase_t             phase_reg,  phase_next;
    logic [NUM_W-1:0]       num_reg,    num_next;
    logic                   seen_reg,   seen_next;
    logic [MS_W-1:0]        base_reg,   base_next;
    logic [2:0]             place_reg,  place_next;
    logic                   neg_reg,    neg_next;
    logic                   failed_reg, failed_next;

    logic [3:0]             digit;
    logic [13:0]            num_wide;
    logic [NUM_W-1:0]       num_sat;
    logic [MS_W-1:0]        hour_add;
    logic [MS_W-1:0]        minute_add;
    logic [MS_W-1:0]        second_add;
    logic [MS_W-1:0]        frac_add;
    dtp_phase_t             group_phase;
    logic                   group_go;
    logic                   is_h, is_m, is_s;

    always_comb begin
        digit      = 4'(text_byte - CH_ZERO);
        num_wide   = 14'(num_reg) * 14'd10 + 14'(digit);
        num_sat    = (num_wide > 14'(NUM_MAX)) ? NUM_W'(NUM_MAX) : num_wide[NUM_W-1:0];
        hour_add   = MS_W'(num_reg * MS_PER_HOUR);
        minute_add = MS_W'(num_reg * MS_PER_MINUTE);
        second_add = MS_W'(num_reg * MS_PER_SECOND);
        is_h       = (text_byte == CH_H_LO) || (text_byte == CH_H_UP);
        is_m       = (text_byte == CH_M_LO) || (text_byte == CH_M_UP);
        is_s       = (text_byte == CH_S_LO) || (text_byte == CH_S_UP);
        case (place_reg)
            3'd0:    frac_add = MS_W'(10'(digit) * 10'd100);
            3'd1:    frac_add = MS_W'(7'(digit) * 7'd10);
            3'd2:    frac_add = MS_W'(digit);
            3'd3:    frac_add = MS_W'(digit >= 4'd5);
            default: frac_add = '0;
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        num_next    = num_reg;
        seen_next   = seen_reg;
        base_next   = base_reg;
        place_next  = place_reg;
        neg_next    = neg_reg;
        failed_next = failed_reg;
        group_go    = 1'b0;
        group_phase = phase_reg;

        if (byte_fire) begin
            if (text_byte == CH_NUL) begin
                phase_next  = PH_START;
                num_next    = '0;
                seen_next   = 1'b0;
                base_next   = '0;
                place_next  = '0;
                neg_next    = 1'b0;
                failed_next = 1'b0;
            end else if (!failed_reg) begin
                unique case (phase_reg) inside
                    PH_START: begin
                        phase_next  = PH_FIRST;
                        group_phase = PH_FIRST;
                        if (text_byte == CH_MINUS) begin
                            neg_next = 1'b1;
                        end else if (text_byte != CH_PLUS) begin
                            group_go = 1'b1;
                        end
                    end
                    PH_FIRST, PH_AFTER_H, PH_AFTER_M: begin
                        group_go = 1'b1;
                    end
                    PH_FRACTION: begin
                        if (is_digit(text_byte)) begin
                            if (place_reg < 3'(FRAC_DIGS)) begin
                                base_next  = base_reg + frac_add;
                                place_next = place_reg + 3'd1;
                            end
                        end else if (is_s) begin
                            phase_next = PH_DONE;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_DONE: begin
                    end
                    default: begin
                        failed_next = 1'b1;
                    end
                endcase

                if (group_go) begin
                    if (is_digit(text_byte)) begin
                        num_next  = num_sat;
                        seen_next = 1'b1;
                    end else if (!seen_reg) begin
                        failed_next = 1'b1;
                    end else if (is_h && group_phase == PH_FIRST) begin
                        if (32'(num_reg) > 32'(MAX_HOURS)) begin
                            failed_next = 1'b1;
                        end else begin
                            base_next  = base_reg + hour_add;
                            phase_next = PH_AFTER_H;
                            num_next   = '0;
                            seen_next  = 1'b0;
                        end
                    end else if (is_m && group_phase != PH_AFTER_M) begin
                        if (32'(num_reg) >= UNIT_LIMIT) begin
                            failed_next = 1'b1;
                        end else begin
                            base_next  = base_reg + minute_add;
                            phase_next = PH_AFTER_M;
                            num_next   = '0;
                            seen_next  = 1'b0;
                        end
                    end else if (is_s || text_byte == CH_POINT) begin
                        if (32'(num_reg) >= UNIT_LIMIT) begin
                            failed_next = 1'b1;
                        end else begin
                            base_next  = base_reg + second_add;
                            phase_next = (text_byte == CH_POINT) ? PH_FRACTION : PH_AFTER_S;
                            num_next   = '0;
                            seen_next  = 1'b0;
                        end
                    end else begin
                        failed_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        verdict.negative = neg_reg;
        verdict.ok       = 1'b0;
        if (!failed_reg) begin
            unique case (phase_reg) inside
                PH_DONE, PH_AFTER_S:   verdict.ok = 1'b1;
                PH_AFTER_H, PH_AFTER_M: verdict.ok = !seen_reg;
                default:               verdict.ok = 1'b0;
            endcase
        end
        total_ms = base_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            num_reg    <= '0;
            seen_reg   <= 1'b0;
            base_reg   <= '0;
            place_reg  <= '0;
            neg_reg    <= 1'b0;
            failed_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            num_reg    <= num_next;
            seen_reg   <= seen_next;
            base_reg   <= base_next;
            place_reg  <= place_next;
            neg_reg    <= neg_next;
            failed_reg <= failed_next;
        end
    end

endmodule

### hdl/dtp_out.sv
module dtp_out
    import dtp_pkg::*;
#(
    parameter int MS_W = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  dtp_verdict_t     verdict,
    input  logic [MS_W-1:0]  total_ms,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic             parse_ok,
    output logic [DUR_W-1:0] duration_ms
);

    logic             valid_reg, valid_next;
    logic             ok_reg,    ok_next;
    logic [DUR_W-1:0] dur_reg,   dur_next;
    logic [DUR_W-1:0] magnitude;

    always_comb begin
        magnitude  = DUR_W'(total_ms);
        valid_next = valid_reg;
        ok_next    = ok_reg;
        dur_next   = dur_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            ok_next    = verdict.ok;
            if (!verdict.ok) begin
                dur_next = '0;
            end else if (verdict.negative) begin
                dur_next = '0 - magnitude;
            end else begin
                dur_next = magnitude;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg  <= ok_next;
        dur_reg <= dur_next;
    end

    assign m_tvalid    = valid_reg;
    assign parse_ok    = ok_reg;
    assign duration_ms = dur_reg;

endmodule

### hdl/duration_text_parser_unit.sv
// One text byte is taken per cycle while s_tready is high; non-terminating bytes produce no result.
// The result for a NUL byte is presented in the cycle after its transfer.
// Input stalls only while a held result is not taken by the downstream side.
// Hour, minute and second contributions are added into a running millisecond
// total as each unit letter or point arrives, so the NUL byte only needs a sign step.
// Synchronous active-low reset returns the parser to its start and drops m_tvalid.
module duration_text_parser_unit
    import dtp_pkg::*;
#(
    parameter int MAX_HOURS = 511
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] text_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [0] parse_ok, [32:1] duration_ms, [39:33] zero
);

    localparam longint unsigned MAX_MS =
        longint'(MAX_HOURS) * longint'(MS_PER_HOUR) + longint'(MS_PER_HOUR);
    localparam int MS_W = $clog2(MAX_MS + 64'd1);

    logic             byte_fire;
    logic             result_load;
    dtp_verdict_t     verdict;
    logic [MS_W-1:0]  total_ms;
    logic             parse_ok;
    logic [DUR_W-1:0] duration_ms;

    assign s_tready    = !m_tvalid || m_tready;
    assign byte_fire   = s_tvalid && s_tready;
    assign result_load = byte_fire && (s_tdata == CH_NUL);

    dtp_parser #(
        .MAX_HOURS (MAX_HOURS),
        .MS_W      (MS_W)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .text_byte (s_tdata),
        .verdict   (verdict),
        .total_ms  (total_ms)
    );

    dtp_out #(
        .MS_W (MS_W)
    ) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (result_load),
        .verdict     (verdict),
        .total_ms    (total_ms),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .parse_ok    (parse_ok),
        .duration_ms (duration_ms)
    );

    assign m_tdata = {(OUT_W - DUR_W - 1)'(0), duration_ms, parse_ok};

endmodule
